[src/piprc_pkg.sv]
package piprc_pkg;

    // Result codes on o_relation.
    typedef enum logic [1:0] {
        REL_SEPARATE = 2'd0,
        REL_TOUCH    = 2'd1,
        REL_WITHIN   = 2'd2
    } t_relation;

    // Per-vertex control that travels with a beat down the pipeline.
    typedef struct packed {
        logic first;   // vertex opens a new polygon, no incoming edge
        logic last;    // vertex closes the polygon, closing edge follows
    } t_ctl;

    // Outcome of one edge test.
    typedef struct packed {
        logic touch;   // point lies on the closed segment
        logic toggle;  // edge crosses the upward ray from the point
    } t_edge_res;

endpackage

[src/piprc_edge.sv]
module piprc_edge #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_load_a,
    input  logic                          i_load_b,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by,
    input  logic signed [COORD_WIDTH-1:0] i_px,
    input  logic signed [COORD_WIDTH-1:0] i_py,
    output piprc_pkg::t_edge_res          o_res
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] n_dax, n_day, n_dbx, n_dby;
    logic                 n_box, n_cross, n_dir;
    logic                 span_x, span_y;

    logic signed [DW-1:0] r_dax, r_day, r_dbx, r_dby;
    logic                 r_box_a, r_cross_a, r_dir_a;

    logic signed [PW-1:0] n_p, n_q;
    logic signed [PW-1:0] r_p, r_q;
    logic                 r_box_b, r_cross_b, r_dir_b;

    // Stage A: offsets from the point and the range flags.
    always_comb begin
        n_dax   = {i_ax[COORD_WIDTH-1], i_ax} - {i_px[COORD_WIDTH-1], i_px};
        n_day   = {i_ay[COORD_WIDTH-1], i_ay} - {i_py[COORD_WIDTH-1], i_py};
        n_dbx   = {i_bx[COORD_WIDTH-1], i_bx} - {i_px[COORD_WIDTH-1], i_px};
        n_dby   = {i_by[COORD_WIDTH-1], i_by} - {i_py[COORD_WIDTH-1], i_py};
        span_x  = (i_ax <= i_px || i_bx <= i_px) && (i_ax >= i_px || i_bx >= i_px);
        span_y  = (i_ay <= i_py || i_by <= i_py) && (i_ay >= i_py || i_by >= i_py);
        n_box   = span_x && span_y;
        // half-open x-span: exactly one end at or left of the point
        n_cross = (i_ax <= i_px) != (i_bx <= i_px);
        n_dir   = i_ax < i_bx;
    end

    always_ff @(posedge i_clk) begin
        if (i_load_a) begin
            r_dax     <= n_dax;
            r_day     <= n_day;
            r_dbx     <= n_dbx;
            r_dby     <= n_dby;
            r_box_a   <= n_box;
            r_cross_a <= n_cross;
            r_dir_a   <= n_dir;
        end
    end

    // Stage B: the two cross-product terms.
    always_comb begin
        n_p = PW'(r_dax) * PW'(r_dby);
        n_q = PW'(r_day) * PW'(r_dbx);
    end

    always_ff @(posedge i_clk) begin
        if (i_load_b) begin
            r_p       <= n_p;
            r_q       <= n_q;
            r_box_b   <= r_box_a;
            r_cross_b <= r_cross_a;
            r_dir_b   <= r_dir_a;
        end
    end

    // Side of the line from the sign of p - q; an edge running left to right
    // lies above the point when the cross product is negative.
    always_comb begin
        o_res.touch  = r_box_b && (r_p == r_q);
        o_res.toggle = r_cross_b && (r_dir_b ? (r_p < r_q) : (r_p > r_q));
    end

endmodule

[src/point_in_polygon_ray_cast.sv]
// Point-in-polygon test by crossing number. Vertices stream in one beat per
// cycle while o_ready is high, each carrying the query point; i_last_vertex
// marks the final vertex of a polygon, and the next beat starts a new polygon.
// Every edge, the closing edge included, is tested exactly in integer
// arithmetic against an upward vertical ray, and one result comes out per
// polygon on o_relation: separate, touch (point on the boundary, which wins
// over within) or within. The block takes one vertex every cycle with no gaps
// between polygons unless a waiting result holds a closing vertex. The last
// vertex passes through the input, offset and product registers before its
// result is loaded into the result register, with both edge tests of a
// closing vertex running side by side. A waiting result only stalls the
// pipeline behind another closing vertex.
module point_in_polygon_ray_cast #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_y,
    input  logic                          i_last_vertex,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_relation
);

    logic accept;

    // polygon tracking state
    logic signed [COORD_WIDTH-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic                          r_await;

    // stage 1: input register
    logic                          r_v1;
    piprc_pkg::t_ctl               r_c1;
    logic signed [COORD_WIDTH-1:0] r_px, r_py, r_vx, r_vy, r_ax, r_ay, r_fx, r_fy;

    // stages 2 and 3 live in the edge units; control travels here
    logic            r_v2, r_v3;
    piprc_pkg::t_ctl r_c2, r_c3;

    logic free1, free2, free3, adv3, out_free;

    piprc_pkg::t_edge_res res_e, res_c;

    logic                 r_parity, r_touch;
    logic                 n_parity, n_touch;
    logic                 r_out_valid;
    piprc_pkg::t_relation r_rel, n_rel;

    // A stage frees up when empty or moving on; a non-closing vertex needs
    // no output space.
    always_comb begin
        out_free = !r_out_valid || i_ready;
        adv3     = r_v3 && (!r_c3.last || out_free);
        free3    = !r_v3 || adv3;
        free2    = !r_v2 || free3;
        free1    = !r_v1 || free2;
        o_ready  = free1;
        accept   = i_valid && free1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_x <= '0;
            r_first_y <= '0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_await   <= 1'b1;
        end else if (accept) begin
            if (r_await) begin
                r_first_x <= i_vertex_x;
                r_first_y <= i_vertex_y;
            end
            r_prev_x <= i_vertex_x;
            r_prev_y <= i_vertex_y;
            r_await  <= i_last_vertex;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px       <= i_point_x;
            r_py       <= i_point_y;
            r_vx       <= i_vertex_x;
            r_vy       <= i_vertex_y;
            r_ax       <= r_prev_x;
            r_ay       <= r_prev_y;
            // a lone vertex closes on itself
            r_fx       <= r_await ? i_vertex_x : r_first_x;
            r_fy       <= r_await ? i_vertex_y : r_first_y;
            r_c1.first <= r_await;
            r_c1.last  <= i_last_vertex;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (free1) begin
                r_v1 <= i_valid;
            end
            if (free2) begin
                r_v2 <= r_v1;
            end
            if (free3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free2) begin
            r_c2 <= r_c1;
        end
        if (free3) begin
            r_c3 <= r_c2;
        end
    end

    // edge from the previous vertex to this one
    piprc_edge #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_edge_in (
        .i_clk   (i_clk),
        .i_load_a(free2),
        .i_load_b(free3),
        .i_ax    (r_ax),
        .i_ay    (r_ay),
        .i_bx    (r_vx),
        .i_by    (r_vy),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_res   (res_e)
    );

    // closing edge back to the first vertex
    piprc_edge #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_edge_close (
        .i_clk   (i_clk),
        .i_load_a(free2),
        .i_load_b(free3),
        .i_ax    (r_vx),
        .i_ay    (r_vy),
        .i_bx    (r_fx),
        .i_by    (r_fy),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_res   (res_c)
    );

    always_comb begin
        n_parity = (r_parity && !r_c3.first)
                 ^ (res_e.toggle && !r_c3.first)
                 ^ (res_c.toggle && r_c3.last);
        n_touch  = (r_touch && !r_c3.first)
                 || (res_e.touch && !r_c3.first)
                 || (res_c.touch && r_c3.last);
        priority if (n_touch) begin
            n_rel = piprc_pkg::REL_TOUCH;
        end else if (n_parity) begin
            n_rel = piprc_pkg::REL_WITHIN;
        end else begin
            n_rel = piprc_pkg::REL_SEPARATE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity    <= 1'b0;
            r_touch     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv3) begin
                r_parity <= n_parity;
                r_touch  <= n_touch;
            end
            if (adv3 && r_c3.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3 && r_c3.last) begin
            r_rel <= n_rel;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_relation = r_rel;

`ifndef SYNTHESIS
    // a closing vertex always arms the start of a new polygon
    a_await_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_last_vertex) |=> r_await)
        else $error("polygon start not armed after last vertex");

    // a closing vertex blocked by a waiting result holds its place
    a_hold_closing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_c3.last && r_out_valid && !i_ready) |=> (r_v3 && r_c3.last))
        else $error("closing vertex lost while result waits");

    // a result only follows a closing vertex leaving the last stage
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid)) |-> $past(r_v3 && r_c3.last))
        else $error("result without a closing vertex");
`endif

endmodule

[verif/point_in_polygon_ray_cast_tb.sv]
`timescale 1ns / 100ps

module point_in_polygon_ray_cast_tb;

    localparam int CW = 16;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic                 o_ready;
    logic signed [CW-1:0] i_point_x     = '0;
    logic signed [CW-1:0] i_point_y     = '0;
    logic signed [CW-1:0] i_vertex_x    = '0;
    logic signed [CW-1:0] i_vertex_y    = '0;
    logic                 i_last_vertex = 1'b0;
    logic                 o_valid;
    logic                 i_ready       = 1'b0;
    logic [1:0]           o_relation;

    int idle_pct  = 0;
    int stall_pct = 0;

    point_in_polygon_ray_cast #(
        .COORD_WIDTH(CW)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_last_vertex (i_last_vertex),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_relation    (o_relation)
    );

    // Crossing-number predictor and queue of relations still owed by the block.
    class polygon_scoreboard;
        longint               first_x, first_y, prev_x, prev_y;
        bit                   parity;
        bit                   touched;
        bit                   opening = 1'b1;
        piprc_pkg::t_relation owed[$];
        int                   n_fail     = 0;
        int                   n_vertices = 0;
        int                   n_rel[3]   = '{0, 0, 0};

        function int side_sign(longint ax, longint ay, longint bx, longint by,
                               longint x, longint y);
            longint c;
            c = (ax - x) * (by - y) - (ay - y) * (bx - x);
            return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
        endfunction

        function void test_edge(longint ax, longint ay, longint bx, longint by,
                                longint x, longint y);
            int s;
            s = side_sign(ax, ay, bx, by, x, y);
            if (s == 0 && ((ax <= x && x <= bx) || (bx <= x && x <= ax)) &&
                ((ay <= y && y <= by) || (by <= y && y <= ay)))
                touched = 1'b1;
            // half-open x-span: a vertex on the ray counts for one edge only
            if ((ax <= x) != (bx <= x)) begin
                if ((ax < bx) ? (s < 0) : (s > 0))
                    parity = ~parity;
            end
        endfunction

        function void note_vertex(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                                  logic signed [CW-1:0] vx, logic signed [CW-1:0] vy,
                                  logic last);
            n_vertices++;
            if (opening) begin
                first_x = vx;
                first_y = vy;
                parity  = 1'b0;
                touched = 1'b0;
                opening = 1'b0;
            end else begin
                test_edge(prev_x, prev_y, vx, vy, px, py);
            end
            prev_x = vx;
            prev_y = vy;
            if (last) begin
                test_edge(vx, vy, first_x, first_y, px, py);
                if (touched)
                    owed.push_back(piprc_pkg::REL_TOUCH);
                else if (parity)
                    owed.push_back(piprc_pkg::REL_WITHIN);
                else
                    owed.push_back(piprc_pkg::REL_SEPARATE);
                opening = 1'b1;
            end
        endfunction

        function void check_relation(logic [1:0] got);
            piprc_pkg::t_relation want;
            if (owed.size() == 0) begin
                $error("relation: got %0d with no polygon pending", got);
                n_fail++;
                return;
            end
            want = owed.pop_front();
            if (got !== want) begin
                $error("relation: expected %0d, got %0d", want, got);
                n_fail++;
            end
            n_rel[want]++;
        endfunction
    endclass

    polygon_scoreboard sb = new;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            sb.note_vertex(i_point_x, i_point_y, i_vertex_x, i_vertex_y, i_last_vertex);
        if (i_rst_n && o_valid && i_ready)
            sb.check_relation(o_relation);
    end

    task automatic send_vertex(input int px, input int py, input int vx, input int vy,
                               input logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_point_x     <= CW'(px);
        i_point_y     <= CW'(py);
        i_vertex_x    <= CW'(vx);
        i_vertex_y    <= CW'(vy);
        i_last_vertex <= last;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_ring(input int px, input int py, input int xs[$], input int ys[$]);
        for (int k = 0; k < xs.size(); k++)
            send_vertex(px, py, xs[k], ys[k], k == xs.size() - 1);
    endtask

    task automatic run_phase(input int idle, input int stall, input int quota);
        int  sent;
        int  n;
        int  span;
        int  cx;
        int  cy;
        int  px;
        int  py;
        int  k;
        int  dx;
        int  dy;
        int  xs[$];
        int  ys[$];
        bit  wander;
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        while (sent < quota) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 8) : $urandom_range(6, 1);
            case ($urandom_range(2))
                0:       span = 3;
                1:       span = 40;
                default: span = 2000;
            endcase
            cx = $urandom_range(50000) - 25000;
            cy = $urandom_range(50000) - 25000;
            xs.delete();
            ys.delete();
            for (int j = 0; j < n; j++) begin
                xs.push_back(cx + $urandom_range(2 * span) - span);
                ys.push_back(cy + $urandom_range(2 * span) - span);
            end
            px = cx + $urandom_range(2 * span) - span;
            py = cy + $urandom_range(2 * span) - span;
            k  = $urandom_range(n - 1);
            case ($urandom_range(9))
                0: begin
                    // full-range noise
                    for (int j = 0; j < n; j++) begin
                        xs[j] = $urandom_range(65535) - 32768;
                        ys[j] = $urandom_range(65535) - 32768;
                    end
                    px = $urandom_range(65535) - 32768;
                    py = $urandom_range(65535) - 32768;
                end
                1: begin
                    px = xs[k];
                    py = ys[k];
                end
                2, 3: begin
                    // put the point midway along one edge
                    if (n >= 2) begin
                        k  = $urandom_range(n - 2);
                        dx = $urandom_range(2 * span) - span;
                        dy = $urandom_range(2 * span) - span;
                        xs[k + 1] = xs[k] + 2 * dx;
                        ys[k + 1] = ys[k] + 2 * dy;
                        px = xs[k] + dx;
                        py = ys[k] + dy;
                    end
                end
                4: px = xs[k];
                default: ;
            endcase
            wander = ($urandom_range(9) == 0);
            for (int j = 0; j < n; j++) begin
                if (wander)
                    send_vertex(px + $urandom_range(4) - 2, py + $urandom_range(4) - 2,
                                xs[j], ys[j], j == n - 1);
                else
                    send_vertex(px, py, xs[j], ys[j], j == n - 1);
            end
            sent += n;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct  = 30;
        stall_pct = 30;
        send_ring(5, -7, '{5}, '{-7});
        send_ring(0, 0, '{-32768}, '{32767});
        send_ring(0, 0, '{-4, 4}, '{-4, 4});
        send_ring(0, -9, '{-4, 4}, '{0, 0});
        send_ring(0, 0, '{-32768, 32767, 32767, -32768}, '{-32768, -32768, 32767, 32767});
        send_ring(32767, 32767, '{-32768, 32767, 32767, -32768},
                  '{-32768, -32768, 32767, 32767});
        send_ring(0, 0, '{0, 0, 5}, '{-5, 5, 0});
        send_ring(0, -10, '{-4, 0, 4, 0}, '{0, 4, 0, -4});
        // point moves while the polygon streams in
        send_vertex(0, 0, -10, -10, 1'b0);
        send_vertex(20, 20, 10, -10, 1'b0);
        send_vertex(0, -10, 0, 10, 1'b1);

        run_phase(0, 0, 480);
        run_phase(82, 0, 480);
        run_phase(0, 82, 480);
        run_phase(14, 14, 480);
        i_valid <= 1'b0;

        while (sb.owed.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("%0d vertices in %0d polygons checked under four handshake phases",
                 sb.n_vertices, sb.n_rel[0] + sb.n_rel[1] + sb.n_rel[2]);
        $display("relations seen: %0d separate, %0d touch, %0d within",
                 sb.n_rel[piprc_pkg::REL_SEPARATE], sb.n_rel[piprc_pkg::REL_TOUCH],
                 sb.n_rel[piprc_pkg::REL_WITHIN]);
        if (sb.n_fail == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
